/* rtl/ohms_pkg.sv */
package ohms_pkg;

    // field widths
    localparam int SONG_W  = 16;
    localparam int TIME_W  = 24;
    localparam int CNT_W   = 16;

    // offset bucket width in time units, and its reciprocal for exact division
    // of any TIME_W-bit magnitude: q = (mag * RECIP) >> RECIP_SHIFT
    localparam int OFFSET_BUCKET = 200;
    localparam int RECIP_W       = 25;
    localparam int RECIP_SHIFT   = 32;
    localparam logic [RECIP_W-1:0] RECIP = 25'd21474837;
    localparam int QUO_W         = 17;

    // histogram epoch tag width: entries of older songs read as zero
    localparam int EPOCH_W = 8;

    // defaults
    localparam int HIST_BINS_DEF   = 1024;
    localparam int RES_Q_DEPTH_DEF = 4;

    // one finished song, and the verdict that follows when the query ends
    typedef struct packed {
        logic [SONG_W-1:0] song;
        logic [CNT_W-1:0]  score;
        logic [CNT_W-1:0]  dropped;
        logic              query_end;
        logic [SONG_W-1:0] lead_song;
        logic [CNT_W-1:0]  lead_score;
    } t_result_pair;

endpackage

/* rtl/ohms_res_queue.sv */
module ohms_res_queue
    import ohms_pkg::*;
#(
    parameter int DEPTH = RES_Q_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result_pair       i_entry,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [SONG_W-1:0]  o_result_song,
    output logic [CNT_W-1:0]   o_score,
    output logic [CNT_W-1:0]   o_dropped,
    output logic               o_last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_result_pair        r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_QW-1:0]   r_count;
    logic                r_verdict;

    t_result_pair        head;
    logic                out_accept;
    logic                pop;

    assign head       = r_mem[r_rd_ptr];
    assign o_valid    = (r_count != '0);
    assign o_full     = (r_count == CNT_QW'(DEPTH));
    assign out_accept = o_valid && !i_stall;
    // an entry leaves after its song item, or after its verdict at query end
    assign pop        = out_accept && (r_verdict || !head.query_end);

    // unpack the head entry into one or two result items
    assign o_kind        = r_verdict;
    assign o_result_song = r_verdict ? head.lead_song : head.song;
    assign o_score       = r_verdict ? head.lead_score : head.score;
    assign o_dropped     = r_verdict ? '0 : head.dropped;
    assign o_last        = r_verdict || !head.query_end;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers, fill count and verdict phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_verdict <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
            if (out_accept) begin
                r_verdict <= !r_verdict && head.query_end;
            end
        end
    end

endmodule

/* rtl/offset_histogram_match_scorer_top.sv */
// Offset histogram match scorer. Takes one matched hit per cycle unless o_stall
// is raised, grouped by song, bins its time offset (db_time - sample_time) / 200
// into a histogram and tracks the song's peak count. A song-ending hit yields a
// score item; a query-ending hit yields the score item and then the best-song
// verdict as two output items. Hits pass through three stages (offset, divide by
// reciprocal multiply, histogram read-modify-write) before their results reach a
// small output queue. The histogram sits in one memory with one read and one
// write port; a write-through bypass covers back-to-back hits to the same bin,
// so one item per cycle is sustained while the output queue has room at song
// ends. Bins carry an 8-bit song epoch tag instead of being cleared per song:
// after reset, and after every 256th song end, a clear pass over all HIST_BINS
// bins runs during which no item is accepted; at a song end it follows a short
// drain of the pipeline, during which no item is accepted either.
module offset_histogram_match_scorer_top
    import ohms_pkg::*;
#(
    parameter int HIST_BINS   = HIST_BINS_DEF,
    parameter int RES_Q_DEPTH = RES_Q_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [SONG_W-1:0]  i_song_id,
    input  logic [TIME_W-1:0]  i_db_time,
    input  logic [TIME_W-1:0]  i_sample_time,
    input  logic               i_song_last,
    input  logic               i_query_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [SONG_W-1:0]  o_result_song,
    output logic [CNT_W-1:0]   o_score,
    output logic [CNT_W-1:0]   o_dropped,
    output logic               o_last
);

    localparam int BIN_W  = $clog2(HIST_BINS);
    localparam int HALF   = HIST_BINS / 2;
    localparam int UP_LIM = HIST_BINS - HALF;
    localparam int PROD_W = TIME_W + RECIP_W;

    typedef struct packed {
        logic [SONG_W-1:0]  sid;
        logic               song_last;
        logic               query_last;
        logic [EPOCH_W-1:0] epoch;
    } t_hit_info;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CNT_W-1:0]   count;
    } t_hist_entry;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_CLEAR
    } t_ctl_state;

    // control
    t_ctl_state          r_state;
    logic [BIN_W-1:0]    r_clr_addr;
    logic [EPOCH_W-1:0]  r_in_epoch;
    logic                adv;
    logic                in_accept;
    logic                in_end;
    logic                pipe_empty;

    // offset stage
    logic                r_a_valid;
    t_hit_info           r_a_info;
    logic [TIME_W-1:0]   r_a_mag;
    logic                r_a_neg;
    logic [TIME_W:0]     diff_pos;
    logic [TIME_W:0]     diff_neg;

    // divide stage
    logic                r_b_valid;
    t_hit_info           r_b_info;
    logic [QUO_W-1:0]    r_b_quo;
    logic                r_b_neg;
    logic [PROD_W-1:0]   prod;
    logic                b_in_range;
    logic [BIN_W-1:0]    b_bin;

    // histogram stage
    logic                r_c_valid;
    t_hit_info           r_c_info;
    logic [BIN_W-1:0]    r_c_bin;
    logic                r_c_in_range;
    t_hist_entry         r_hist [HIST_BINS];
    t_hist_entry         r_rd_data;
    logic                r_fwd_hit;
    logic [CNT_W-1:0]    r_fwd_cnt;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    cnt_new;
    logic                c_end;
    logic                c_wr_en;
    logic                mem_we;
    logic [BIN_W-1:0]    mem_wa;
    t_hist_entry         mem_wd;
    logic                rd_en;

    // song and query state
    logic [CNT_W-1:0]    r_peak;
    logic [CNT_W-1:0]    r_drop;
    logic [SONG_W-1:0]   r_lead_song;
    logic [CNT_W-1:0]    r_lead_score;
    logic [CNT_W-1:0]    n_peak;
    logic [CNT_W-1:0]    n_drop;
    logic [SONG_W-1:0]   n_lead_song;
    logic [CNT_W-1:0]    n_lead_score;

    // result queue
    logic                q_full;
    logic                q_push;
    t_result_pair        q_entry;

    // input handshake and global advance
    assign c_end      = r_c_info.song_last || r_c_info.query_last;
    assign adv        = !(r_c_valid && c_end && q_full);
    assign o_stall    = !adv || (r_state != ST_RUN);
    assign in_accept  = i_valid && !o_stall;
    assign in_end     = i_song_last || i_query_last;
    assign pipe_empty = !r_a_valid && !r_b_valid && !r_c_valid;

    // signed offset as sign and magnitude
    assign diff_pos = {1'b0, i_db_time} - {1'b0, i_sample_time};
    assign diff_neg = {1'b0, i_sample_time} - {1'b0, i_db_time};

    // divide by the bucket width through the reciprocal
    assign prod = PROD_W'(r_a_mag) * PROD_W'(RECIP);

    // bin mapping, bucket truncated toward zero
    always_comb begin
        if (r_b_neg) begin
            b_in_range = (r_b_quo <= QUO_W'(HALF));
            b_bin      = BIN_W'(HALF) - r_b_quo[BIN_W-1:0];
        end else begin
            b_in_range = (r_b_quo < QUO_W'(UP_LIM));
            b_bin      = BIN_W'(HALF) + r_b_quo[BIN_W-1:0];
        end
    end

    // bin count with bypass of the write in flight; other epochs read as zero
    always_comb begin
        if (r_fwd_hit) begin
            cnt_cur = r_fwd_cnt;
        end else if (r_rd_data.epoch == r_c_info.epoch) begin
            cnt_cur = r_rd_data.count;
        end else begin
            cnt_cur = '0;
        end
        cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
    end

    // peak, drop count and best song
    always_comb begin
        n_peak = r_peak;
        n_drop = r_drop;
        if (r_c_in_range) begin
            if (cnt_new > r_peak) begin
                n_peak = cnt_new;
            end
        end else if (r_drop != '1) begin
            n_drop = r_drop + 1'b1;
        end
        n_lead_song  = r_lead_song;
        n_lead_score = r_lead_score;
        if (n_peak > r_lead_score) begin
            n_lead_song  = r_c_info.sid;
            n_lead_score = n_peak;
        end
    end

    // memory port control
    assign c_wr_en = adv && r_c_valid && r_c_in_range;
    assign mem_we  = (r_state == ST_CLEAR) || c_wr_en;
    assign mem_wa  = (r_state == ST_CLEAR) ? r_clr_addr : r_c_bin;
    assign mem_wd  = (r_state == ST_CLEAR) ? t_hist_entry'('0)
                                           : t_hist_entry'{epoch: r_c_info.epoch,
                                                           count: cnt_new};
    assign rd_en   = adv && r_b_valid && b_in_range;

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[b_bin];
        end
    end

    // clear sequencing: after reset and when the epoch tag wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (in_accept && in_end && (r_in_epoch == '1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        r_state    <= ST_CLEAR;
                        r_clr_addr <= '0;
                    end
                end
                ST_CLEAR: begin
                    if (r_clr_addr == BIN_W'(HIST_BINS - 1)) begin
                        r_state <= ST_RUN;
                    end
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // song epoch for incoming items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_epoch <= '0;
        end else if (in_accept && in_end) begin
            r_in_epoch <= r_in_epoch + 1'b1;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= in_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_info     <= '{sid: i_song_id, song_last: i_song_last,
                              query_last: i_query_last, epoch: r_in_epoch};
            r_a_neg      <= diff_pos[TIME_W];
            r_a_mag      <= diff_pos[TIME_W] ? diff_neg[TIME_W-1:0] : diff_pos[TIME_W-1:0];
            r_b_info     <= r_a_info;
            r_b_neg      <= r_a_neg;
            r_b_quo      <= prod[RECIP_SHIFT +: QUO_W];
            r_c_info     <= r_b_info;
            r_c_bin      <= b_bin;
            r_c_in_range <= b_in_range;
            // the write at this edge is not seen by the read at this edge
            r_fwd_hit    <= c_wr_en && (r_c_bin == b_bin)
                            && (r_c_info.epoch == r_b_info.epoch);
            r_fwd_cnt    <= cnt_new;
        end
    end

    // per-song and per-query state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_drop       <= '0;
            r_lead_song  <= '0;
            r_lead_score <= '0;
        end else if (adv && r_c_valid) begin
            if (c_end) begin
                r_peak <= '0;
                r_drop <= '0;
            end else begin
                r_peak <= n_peak;
                r_drop <= n_drop;
            end
            if (r_c_info.query_last) begin
                r_lead_song  <= '0;
                r_lead_score <= '0;
            end else if (c_end) begin
                r_lead_song  <= n_lead_song;
                r_lead_score <= n_lead_score;
            end
        end
    end

    // results of a song end towards the output queue
    assign q_push  = adv && r_c_valid && c_end;
    assign q_entry = '{song: r_c_info.sid, score: n_peak, dropped: n_drop,
                       query_end: r_c_info.query_last,
                       lead_song: n_lead_song, lead_score: n_lead_score};

    ohms_res_queue #(
        .DEPTH(RES_Q_DEPTH)
    ) u_res_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_push),
        .i_entry       (q_entry),
        .o_full        (q_full),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_result_song (o_result_song),
        .o_score       (o_score),
        .o_dropped     (o_dropped),
        .o_last        (o_last)
    );

endmodule
